[sv/ale_pkg.sv]
package ale_pkg;

  localparam int DEPTH_DEFAULT = 128;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_ROTL   = 3'd2;
  localparam logic [2:0] KIND_ROTR   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         count_now;
    logic [1:0]         status;
  } rsp_t;

endpackage

[sv/array_list_edit_engine.sv]
// A rejection raises done in the cycle after its transfer; a read goes through S_RDOUT.
// Insert, delete and rotate shift entries in S_MOVE; S_FINAL writes any held entry and the count.
// One request at a time; busy is high until the result strobe and stays low on a rejection.
// The list memory has one read and one write port, so a shift moves one entry per cycle.
// Synchronous reset empties the list; entries need no clearing. The receiver cannot stall.
module array_list_edit_engine
  import ale_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > 8) ? CW : 8;

  typedef enum logic [1:0] {S_IDLE, S_MOVE, S_FINAL, S_RDOUT} state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [CW-1:0] left;
  logic [AW-1:0] src;
  logic [AW-1:0] pend_dst;
  logic [AW-1:0] final_addr;
  logic          up;
  logic          pend;
  logic          keep_pend;
  logic          has_final;
  logic          inc;
  logic          dec;
  logic [31:0]   hold;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [W-1:0]  pos_w;
  logic [W-1:0]  fill_w;
  logic [W-1:0]  fill_next_w;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] fill_next;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] fm1;
  logic [AW-1:0] fm2;
  logic [AW-1:0] one_a;
  logic          full;
  logic          empty;

  assign busy   = (state != S_IDLE);
  assign pos_w  = W'(req.position);
  assign fill_w = W'(fill);
  assign pos_c  = pos_w[CW-1:0];
  assign pos_a  = pos_w[AW-1:0];
  assign fm1    = AW'(fill - CW'(1));
  assign fm2    = AW'(fill - CW'(2));
  assign one_a  = AW'(1);
  assign full   = (fill == CW'(DEPTH));
  assign empty  = (fill == '0);

  always_comb begin
    fill_next = fill;
    if (inc) begin
      fill_next = fill + CW'(1);
    end else if (dec) begin
      fill_next = fill - CW'(1);
    end
  end
  assign fill_next_w = W'(fill_next);

  always_comb begin
    raddr = pos_a;
    if (state == S_MOVE) begin
      raddr = src;
    end else if (req.kind == KIND_ROTR) begin
      raddr = fm1;
    end else if (req.kind == KIND_ROTL) begin
      raddr = '0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pend_dst;
    wdata = rdata;
    if (state == S_MOVE && pend) begin
      we = 1'b1;
    end else if (state == S_FINAL && has_final) begin
      we    = 1'b1;
      waddr = final_addr;
      wdata = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      done      <= 1'b0;
      pend      <= 1'b0;
      keep_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            inc       <= 1'b0;
            dec       <= 1'b0;
            has_final <= 1'b1;
            pend      <= 1'b0;
            keep_pend <= 1'b0;
            rsp.read_value <= '0;
            rsp.count_now  <= fill_w[7:0];
            rsp.status     <= ST_OK;
            unique case (req.kind)
              KIND_INSERT: begin
                if (full) begin
                  done       <= 1'b1;
                  rsp.status <= ST_FULL;
                end else if (pos_w > fill_w) begin
                  done       <= 1'b1;
                  rsp.status <= ST_RANGE;
                end else begin
                  hold       <= req.value;
                  left       <= fill - pos_c;
                  src        <= fm1;
                  up         <= 1'b0;
                  final_addr <= pos_a;
                  inc        <= 1'b1;
                  state      <= S_MOVE;
                end
              end
              KIND_DELETE: begin
                if (empty) begin
                  done       <= 1'b1;
                  rsp.status <= ST_EMPTY;
                end else if (pos_w >= fill_w) begin
                  done       <= 1'b1;
                  rsp.status <= ST_RANGE;
                end else begin
                  left      <= fill - pos_c - CW'(1);
                  src       <= pos_a + one_a;
                  up        <= 1'b1;
                  has_final <= 1'b0;
                  dec       <= 1'b1;
                  state     <= S_MOVE;
                end
              end
              KIND_ROTL, KIND_ROTR: begin
                if (empty) begin
                  done       <= 1'b1;
                  rsp.status <= ST_EMPTY;
                end else begin
                  left      <= fill - CW'(1);
                  keep_pend <= 1'b1;
                  if (req.kind == KIND_ROTL) begin
                    src        <= one_a;
                    up         <= 1'b1;
                    final_addr <= fm1;
                  end else begin
                    src        <= fm2;
                    up         <= 1'b0;
                    final_addr <= '0;
                  end
                  state <= S_MOVE;
                end
              end
              KIND_READ: begin
                if (empty) begin
                  done       <= 1'b1;
                  rsp.status <= ST_EMPTY;
                end else if (pos_w >= fill_w) begin
                  done       <= 1'b1;
                  rsp.status <= ST_RANGE;
                end else begin
                  state <= S_RDOUT;
                end
              end
              default: begin
                done       <= 1'b1;
                rsp.status <= ST_RANGE;
              end
            endcase
          end
        end
        S_MOVE: begin
          if (keep_pend) begin
            hold      <= rdata;
            keep_pend <= 1'b0;
          end
          if (left != '0) begin
            src      <= up ? src + one_a : src - one_a;
            pend_dst <= up ? src - one_a : src + one_a;
            left     <= left - CW'(1);
            pend     <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          fill           <= fill_next;
          done           <= 1'b1;
          rsp.read_value <= '0;
          rsp.count_now  <= fill_next_w[7:0];
          rsp.status     <= ST_OK;
          state          <= S_IDLE;
        end
        S_RDOUT: begin
          done           <= 1'b1;
          rsp.read_value <= rdata;
          rsp.count_now  <= fill_w[7:0];
          rsp.status     <= ST_OK;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
